FILE: design/confusion_matrix_metrics_defines.svh
// ----------------------------------------------------------------------------
// Confusion matrix metrics assertion macros
// Concurrent check helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CONFUSION_MATRIX_METRICS_DEFINES_SVH
`define CONFUSION_MATRIX_METRICS_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define CMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmm assertion failed");
// next-cycle implication
`define CMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmm assertion failed");
`else
`define CMM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CMM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/cmm_pkg.sv
// ----------------------------------------------------------------------------
// Confusion matrix metrics package
// Shared constants, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package cmm_pkg;

    localparam int CLASSES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 32;
    localparam int CFG_W          = 5;
    localparam int CLASS_W        = 4;
    localparam int Q_W            = 17;
    localparam int OUT_W          = 32;

    localparam logic [CFG_W-1:0] CIU_RESET = 5'd16;
    localparam logic [Q_W-1:0]   Q16_ONE   = 17'h10000;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic STS_OK    = 1'b0;
    localparam logic STS_RANGE = 1'b1;

    typedef enum logic [1:0] {
        SEL_PREC = 2'd0,
        SEL_REC  = 2'd1,
        SEL_F1   = 2'd2,
        SEL_ACC  = 2'd3
    } t_div_sel;

    typedef struct packed {
        logic     clr_we;
        logic     capture;
        logic     update;
        logic     div_start;
        logic     div_capture;
        logic     load_out;
        t_div_sel sel;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic mode;
        logic clr_last;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

FILE: design/cmm_ifs.sv
// ----------------------------------------------------------------------------
// Confusion matrix metrics channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cmm_in_if import cmm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [CLASS_W-1:0] actual_class;
    logic [CLASS_W-1:0] predicted_class;

    modport source (output valid, mode, actual_class, predicted_class, input ready);
    modport sink   (input valid, mode, actual_class, predicted_class, output ready);
endinterface

interface cmm_out_if import cmm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic [Q_W-1:0]   precision_q16;
    logic [Q_W-1:0]   recall_q16;
    logic [Q_W-1:0]   f1_q16;
    logic [OUT_W-1:0] support;
    logic [OUT_W-1:0] cell_count;
    logic [Q_W-1:0]   accuracy_q16;
    logic [OUT_W-1:0] total_count;

    modport source (output valid, status, precision_q16, recall_q16, f1_q16, support,
                    cell_count, accuracy_q16, total_count, input ready);
    modport sink   (input valid, status, precision_q16, recall_q16, f1_q16, support,
                    cell_count, accuracy_q16, total_count, output ready);
endinterface

FILE: design/cmm_div.sv
// ----------------------------------------------------------------------------
// Confusion matrix metrics divider
// Restoring divider, one quotient bit per cycle, Q1.16 result.
// ----------------------------------------------------------------------------
module cmm_div import cmm_pkg::*; #(
    parameter int NW = COUNT_BITS_DEF + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    output logic          o_done,
    output logic [Q_W-1:0] o_q
);

    logic           r_busy;
    logic [4:0]     r_cnt;
    logic [NW-1:0]  r_rem;
    logic [NW-1:0]  r_den;
    logic [Q_W-1:0] r_q;
    logic [NW:0]    w_shift;
    logic           w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign o_done  = r_busy && (r_cnt == 5'd0);
    assign o_q     = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= ((i_den == '0) || (i_num >= i_den)) ? 5'd0 : 5'd16;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_num;
            if (i_den == '0) begin
                r_q <= '0;
            end else if (i_num >= i_den) begin
                r_q <= Q16_ONE;
            end else begin
                r_q <= '0;
            end
        end else if (r_busy && (r_cnt != 5'd0)) begin
            // shift in one quotient bit, subtract when it fits
            r_rem <= w_ge ? NW'(w_shift - {1'b0, r_den}) : NW'(w_shift);
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

endmodule

FILE: design/cmm_ctrl.sv
// ----------------------------------------------------------------------------
// Confusion matrix metrics controller
// Sequences clearing, update, shared divisions and result hand-off.
// ----------------------------------------------------------------------------
`include "confusion_matrix_metrics_defines.svh"

module cmm_ctrl import cmm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_UPD   = 6'b000100,
        S_DIV   = 6'b001000,
        S_WAIT  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state   r_state, n_state;
    t_div_sel r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sel   <= SEL_PREC;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_stat.bad ? S_FIN : S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_sel   = (i_stat.mode == MODE_RECORD) ? SEL_ACC : SEL_PREC;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    if (r_sel == SEL_ACC) begin
                        n_state = S_FIN;
                    end else begin
                        n_sel   = t_div_sel'(r_sel + 2'd1);
                        n_state = S_DIV;
                    end
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    `CMM_ASSERT_NXT(a_accept_moves_on, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid, (r_state == S_UPD) || (r_state == S_FIN))
    `CMM_ASSERT_NXT(a_fin_to_idle, i_clk, i_rst_n, (r_state == S_FIN) && i_stat.out_free, r_state == S_IDLE)
    `CMM_ASSERT_NXT(a_acc_last, i_clk, i_rst_n, (r_state == S_WAIT) && i_stat.div_done && (r_sel == SEL_ACC), r_state == S_FIN)

endmodule

FILE: design/cmm_dp.sv
// ----------------------------------------------------------------------------
// Confusion matrix metrics datapath
// Count memories, totals, shared divider and result register.
// ----------------------------------------------------------------------------
module cmm_dp import cmm_pkg::*; #(
    parameter int CLASSES    = CLASSES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_mode,
    input  logic [CLASS_W-1:0] i_actual_class,
    input  logic [CLASS_W-1:0] i_predicted_class,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_status,
    output logic [Q_W-1:0]     o_precision_q16,
    output logic [Q_W-1:0]     o_recall_q16,
    output logic [Q_W-1:0]     o_f1_q16,
    output logic [OUT_W-1:0]   o_support,
    output logic [OUT_W-1:0]   o_cell_count,
    output logic [Q_W-1:0]     o_accuracy_q16,
    output logic [OUT_W-1:0]   o_total_count
);

    localparam int CELLS = CLASSES * CLASSES;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(CLASSES);
    localparam int CB    = COUNT_BITS;
    localparam int NW    = CB + 1;

    logic [CB-1:0] cell_mem [CELLS];
    logic [CB-1:0] row_mem  [CLASSES];
    logic [CB-1:0] col_mem  [CLASSES];

    logic [CFG_W-1:0] r_ciu;
    logic [AW-1:0]    r_clr_cnt;
    logic [CB-1:0]    r_total, r_correct;
    logic             r_out_valid;

    logic             r_mode, r_bad;
    logic [RW-1:0]    r_a, r_p;
    logic [AW-1:0]    r_addr;
    logic [CB-1:0]    r_cell, r_tp, r_row, r_col;
    logic [Q_W-1:0]   r_prec, r_rec, r_f1, r_acc;

    logic             r_res_status;
    logic [Q_W-1:0]   r_res_prec, r_res_rec, r_res_f1, r_res_acc;
    logic [OUT_W-1:0] r_res_support, r_res_cell, r_res_total;

    int               w_lim;
    logic             w_bad;
    logic [AW-1:0]    w_addr_cp, w_addr_aa;
    logic [NW-1:0]    w_num, w_den;
    logic             w_done;
    logic [Q_W-1:0]   w_q;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == '1) ? v : v + CB'(1);
    endfunction

    function automatic logic [OUT_W-1:0] show32(input logic [CB-1:0] v);
        return (64'(v) > 64'hFFFF_FFFF) ? '1 : OUT_W'(v);
    endfunction

    // range check against the class count in use, saturated to CLASSES
    assign w_lim = (32'(r_ciu) > CLASSES) ? CLASSES : 32'(r_ciu);
    assign w_bad = (32'(i_actual_class) >= w_lim) || (32'(i_predicted_class) >= w_lim);
    assign w_addr_cp = AW'(32'(i_actual_class) * CLASSES + 32'(i_predicted_class));
    assign w_addr_aa = AW'(32'(i_actual_class) * CLASSES + 32'(i_actual_class));

    assign o_stat.bad      = w_bad;
    assign o_stat.mode     = r_mode;
    assign o_stat.clr_last = (r_clr_cnt == AW'(CELLS - 1));
    assign o_stat.div_done = w_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ciu <= CIU_RESET;
        end else if (i_cfg_we) begin
            r_ciu <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_total   <= '0;
            r_correct <= '0;
        end else begin
            if (i_cmd.clr_we) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.update && (r_mode == MODE_RECORD)) begin
                r_total <= sat_inc(r_total);
                if (r_a == r_p) begin
                    r_correct <= sat_inc(r_correct);
                end
            end
        end
    end

    // memory writes: clearing sweep or one record update
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            cell_mem[r_clr_cnt]         <= '0;
            row_mem[r_clr_cnt[RW-1:0]]  <= '0;
            col_mem[r_clr_cnt[RW-1:0]]  <= '0;
        end else if (i_cmd.update && (r_mode == MODE_RECORD)) begin
            cell_mem[r_addr] <= sat_inc(r_cell);
            row_mem[r_a]     <= sat_inc(r_row);
            col_mem[r_p]     <= sat_inc(r_col);
        end
    end

    // registered reads at request acceptance
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_bad  <= w_bad;
            r_a    <= RW'(i_actual_class);
            r_p    <= RW'(i_predicted_class);
            r_addr <= w_addr_cp;
            r_cell <= cell_mem[w_addr_cp];
            r_tp   <= cell_mem[w_addr_aa];
            r_row  <= row_mem[RW'(i_actual_class)];
            r_col  <= col_mem[(i_mode == MODE_RECORD) ? RW'(i_predicted_class)
                                                      : RW'(i_actual_class)];
        end
    end

    always_comb begin
        unique case (i_cmd.sel)
            SEL_PREC: begin
                w_num = NW'(r_tp);
                w_den = NW'(r_col);
            end
            SEL_REC: begin
                w_num = NW'(r_tp);
                w_den = NW'(r_row);
            end
            SEL_F1: begin
                w_num = {r_tp, 1'b0};
                w_den = NW'(r_row) + NW'(r_col);
            end
            SEL_ACC: begin
                w_num = NW'(r_correct);
                w_den = NW'(r_total);
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    cmm_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_q     (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_capture) begin
            unique case (i_cmd.sel)
                SEL_PREC: r_prec <= w_q;
                SEL_REC:  r_rec  <= w_q;
                SEL_F1:   r_f1   <= w_q;
                SEL_ACC:  r_acc  <= w_q;
                default:  r_acc  <= w_q;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_res_status  <= r_bad ? STS_RANGE : STS_OK;
            r_res_prec    <= '0;
            r_res_rec     <= '0;
            r_res_f1      <= '0;
            r_res_support <= '0;
            r_res_cell    <= '0;
            r_res_acc     <= '0;
            r_res_total   <= '0;
            if (!r_bad) begin
                r_res_acc   <= r_acc;
                r_res_total <= show32(r_total);
                if (r_mode == MODE_QUERY) begin
                    r_res_prec    <= r_prec;
                    r_res_rec     <= r_rec;
                    r_res_f1      <= r_f1;
                    r_res_support <= show32(r_row);
                    r_res_cell    <= show32(r_cell);
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_res_status;
    assign o_precision_q16 = r_res_prec;
    assign o_recall_q16    = r_res_rec;
    assign o_f1_q16        = r_res_f1;
    assign o_support       = r_res_support;
    assign o_cell_count    = r_res_cell;
    assign o_accuracy_q16  = r_res_acc;
    assign o_total_count   = r_res_total;

endmodule

FILE: design/confusion_matrix_metrics.sv
// ----------------------------------------------------------------------------
// Confusion matrix metrics
// Saturating confusion matrix with per-class precision, recall, F1 queries.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                   Handshake
// i_in      in   mode, actual_class, predicted_class       valid/ready
// o_out     out  status, three ratios, support, cell,      valid/ready
//                accuracy, total
// i_cfg     in   classes_in_use (5 bits)                   write enable only
//
// After reset a clearing sweep zeroes all CLASSES*CLASSES cells, ready low.
// A record request makes one divider pass, a query four passes, and a rejected
// index none. The one shared restoring divider skips its bit loop when the
// denominator is zero or the ratio is one.
// Hold a finished result in the output register; the next request is taken
// meanwhile and stalls only at its final hand-off until the register frees.
// ----------------------------------------------------------------------------
module confusion_matrix_metrics import cmm_pkg::*; #(
    parameter int CLASSES    = CLASSES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    cmm_in_if.sink           i_in,
    cmm_out_if.source        o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // controller: sequence clear, update, divisions and hand-off
    cmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    // datapath: count memories, totals, divider, result register
    cmm_dp #(
        .CLASSES    (CLASSES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_in.mode),
        .i_actual_class    (i_in.actual_class),
        .i_predicted_class (i_in.predicted_class),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_status          (o_out.status),
        .o_precision_q16   (o_out.precision_q16),
        .o_recall_q16      (o_out.recall_q16),
        .o_f1_q16          (o_out.f1_q16),
        .o_support         (o_out.support),
        .o_cell_count      (o_out.cell_count),
        .o_accuracy_q16    (o_out.accuracy_q16),
        .o_total_count     (o_out.total_count)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Confusion matrix metrics testbench
// Drives record and query requests with random idling and checks every
// result field against a behavioral matrix model kept inside the bench.
// ----------------------------------------------------------------------------
module testbench import cmm_pkg::*; ();

    localparam int NCLS        = 16;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_TICKS = 120;

    typedef struct packed {
        logic             status;
        logic [Q_W-1:0]   precision_q16;
        logic [Q_W-1:0]   recall_q16;
        logic [Q_W-1:0]   f1_q16;
        logic [OUT_W-1:0] support;
        logic [OUT_W-1:0] cell_count;
        logic [Q_W-1:0]   accuracy_q16;
        logic [OUT_W-1:0] total_count;
    } t_metrics;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    cmm_in_if  req_ch ();
    cmm_out_if res_ch ();

    confusion_matrix_metrics u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_ch.sink),
        .o_out      (res_ch.source)
    );

    // Model of the matrix state, all counters saturate at 32 bits.
    logic [31:0]      cells [NCLS][NCLS];
    logic [31:0]      row_tot [NCLS];
    logic [31:0]      col_tot [NCLS];
    logic [31:0]      samples;
    logic [31:0]      hits;
    logic [CFG_W-1:0] classes_cfg;

    t_metrics expected_q[$];
    int       mismatches;
    int       idle_cycles;
    bit       sink_stalls;
    bit       source_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // floor(num * 65536 / den), clamped to one, zero for an empty denominator
    function automatic logic [Q_W-1:0] q16_ratio(input logic [33:0] num,
                                                 input logic [33:0] den);
        logic [63:0] wide;
        if (den == 0) return '0;
        if (num >= den) return Q16_ONE;
        wide = ({30'd0, num} << 16) / {30'd0, den};
        return wide[Q_W-1:0];
    endfunction

    // Apply one request to the model and return its result.
    function automatic t_metrics predict_metrics(input logic md, input logic [3:0] a,
                                                 input logic [3:0] p);
        t_metrics r;
        int lim;
        logic [31:0] tp;
        r   = '0;
        lim = (classes_cfg > NCLS) ? NCLS : classes_cfg;
        if (a >= lim || p >= lim) begin
            r.status = STS_RANGE;
            return r;
        end
        if (md == MODE_RECORD) begin
            cells[a][p] = sat_inc(cells[a][p]);
            row_tot[a]  = sat_inc(row_tot[a]);
            col_tot[p]  = sat_inc(col_tot[p]);
            samples     = sat_inc(samples);
            if (a == p) hits = sat_inc(hits);
        end else begin
            tp              = cells[a][a];
            r.precision_q16 = q16_ratio(34'(tp), 34'(col_tot[a]));
            r.recall_q16    = q16_ratio(34'(tp), 34'(row_tot[a]));
            r.f1_q16        = q16_ratio(34'({tp, 1'b0}),
                                        34'(row_tot[a]) + 34'(col_tot[a]));
            r.support       = row_tot[a];
            r.cell_count    = cells[a][p];
        end
        r.status       = STS_OK;
        r.accuracy_q16 = q16_ratio(34'(hits), 34'(samples));
        r.total_count  = samples;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Send one request, with an optional idle burst before it; valid stays
    // high after acceptance until the next request or an explicit drop.
    task automatic send_request(input logic md, input logic [3:0] a, input logic [3:0] p);
        int gap;
        if (source_gaps && $urandom_range(3) == 0) begin
            gap = $urandom_range(19, 1);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.mode            <= md;
        req_ch.actual_class    <= a;
        req_ch.predicted_class <= p;
        expected_q.insert(expected_q.size(), predict_metrics(md, a, p));
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait for every result, then let the block settle before a register write.
    task automatic write_classes(input logic [CFG_W-1:0] n);
        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_TICKS) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_data  <= n;
        classes_cfg = n;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_metrics want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 64'd1, 64'd0);
            end else begin
                want = expected_q.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", 64'(res_ch.status), 64'(want.status));
                if (res_ch.precision_q16 !== want.precision_q16)
                    report_mismatch("precision", 64'(res_ch.precision_q16),
                                    64'(want.precision_q16));
                if (res_ch.recall_q16 !== want.recall_q16)
                    report_mismatch("recall", 64'(res_ch.recall_q16), 64'(want.recall_q16));
                if (res_ch.f1_q16 !== want.f1_q16)
                    report_mismatch("f1", 64'(res_ch.f1_q16), 64'(want.f1_q16));
                if (res_ch.support !== want.support)
                    report_mismatch("support", 64'(res_ch.support), 64'(want.support));
                if (res_ch.cell_count !== want.cell_count)
                    report_mismatch("cell", 64'(res_ch.cell_count), 64'(want.cell_count));
                if (res_ch.accuracy_q16 !== want.accuracy_q16)
                    report_mismatch("accuracy", 64'(res_ch.accuracy_q16),
                                    64'(want.accuracy_q16));
                if (res_ch.total_count !== want.total_count)
                    report_mismatch("total", 64'(res_ch.total_count), 64'(want.total_count));
            end
        end
    end

    // Hold ready low in random bursts while stalls are enabled.
    initial begin
        int burst;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_stalls && $urandom_range(4) == 0) begin
                burst = $urandom_range(19, 1);
                res_ch.ready <= 1'b0;
                repeat (burst) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: count cycles in which no request and no result moves.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[confusion_matrix_metrics] ERROR");
            $finish;
        end
    end

    // Corner values of both class fields and both modes, then the empty class.
    task automatic test_directed();
        send_request(MODE_QUERY, 4'd0, 4'd0);
        send_request(MODE_RECORD, 4'd0, 4'd0);
        send_request(MODE_RECORD, 4'd15, 4'd15);
        send_request(MODE_RECORD, 4'd15, 4'd0);
        send_request(MODE_RECORD, 4'd0, 4'd15);
        send_request(MODE_RECORD, 4'd5, 4'd10);
        send_request(MODE_QUERY, 4'd0, 4'd15);
        send_request(MODE_QUERY, 4'd15, 4'd0);
        send_request(MODE_QUERY, 4'd5, 4'd10);
        send_request(MODE_QUERY, 4'd10, 4'd5);
        send_request(MODE_QUERY, 4'd7, 4'd7);
    endtask

    // Shrink the class count, drive out-of-range indexes, and use the extremes.
    task automatic test_class_limit();
        write_classes(5'd2);
        send_request(MODE_RECORD, 4'd1, 4'd0);
        send_request(MODE_RECORD, 4'd2, 4'd0);
        send_request(MODE_RECORD, 4'd0, 4'd2);
        send_request(MODE_QUERY, 4'd1, 4'd0);
        send_request(MODE_QUERY, 4'd15, 4'd1);
        write_classes(5'd0);
        send_request(MODE_RECORD, 4'd0, 4'd0);
        send_request(MODE_QUERY, 4'd0, 4'd0);
        write_classes(5'd1);
        send_request(MODE_RECORD, 4'd0, 4'd0);
        send_request(MODE_QUERY, 4'd0, 4'd1);
        write_classes(5'd31);
        send_request(MODE_QUERY, 4'd15, 4'd15);
        send_request(MODE_RECORD, 4'd15, 4'd14);
    endtask

    // Mostly records with some queries, under several class counts.
    task automatic test_random(input int count, input logic [CFG_W-1:0] n);
        logic [3:0] a;
        logic [3:0] p;
        logic md;
        write_classes(n);
        repeat (count) begin
            md = ($urandom_range(3) == 0) ? MODE_QUERY : MODE_RECORD;
            if ($urandom_range(9) == 0) begin
                a = 4'($urandom);
                p = 4'($urandom);
            end else begin
                a = 4'($urandom_range(n > NCLS ? NCLS - 1 : n - 1));
                p = ($urandom_range(1) == 0) ? a
                    : 4'($urandom_range(n > NCLS ? NCLS - 1 : n - 1));
            end
            send_request(md, a, p);
        end
    endtask

    initial begin
        for (int r = 0; r < NCLS; r++) begin
            row_tot[r] = '0;
            col_tot[r] = '0;
            for (int c = 0; c < NCLS; c++) cells[r][c] = '0;
        end
        samples                = '0;
        hits                   = '0;
        classes_cfg            = CIU_RESET;
        mismatches             = 0;
        idle_cycles            = 0;
        sink_stalls            = 1'b0;
        source_gaps            = 1'b0;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_data             = '0;
        req_ch.valid           = 1'b0;
        req_ch.mode            = MODE_RECORD;
        req_ch.actual_class    = '0;
        req_ch.predicted_class = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        sink_stalls = 1'b1;
        source_gaps = 1'b1;
        test_class_limit();
        test_random(120, 5'd16);
        test_random(80, 5'd3);
        sink_stalls = 1'b0;
        source_gaps = 1'b0;
        test_random(60, 5'd9);
        sink_stalls = 1'b1;
        source_gaps = 1'b1;
        test_random(100, 5'd16);
        // final stretch: no idling on either side
        sink_stalls = 1'b0;
        source_gaps = 1'b0;
        test_random(70, 5'd16);

        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_TICKS) @(negedge i_clk);
        if (mismatches == 0)
            $display("[confusion_matrix_metrics] OK");
        else
            $display("[confusion_matrix_metrics] ERROR");
        $finish;
    end
endmodule
